[rtl/assert_macros.svh]
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/i2cm_pkg.sv]
// types and constants of the i2c master bit engine
package i2cm_pkg;

  // command codes, idle takes the one undefined mode code
  typedef enum logic [2:0] {
    OP_START    = 3'd0,
    OP_STOP     = 3'd1,
    OP_WRITE    = 3'd2,
    OP_READ     = 3'd3,
    OP_ACK      = 3'd4,
    OP_NACK     = 3'd5,
    OP_WAIT_ACK = 3'd6,
    OP_IDLE     = 3'd7
  } op_e;

  localparam logic [1:0]  PhasesStartStop = 2'd3;
  localparam logic [1:0]  PhasesBit       = 2'd2;
  localparam logic [2:0]  LastBit         = 3'd7;

  localparam int unsigned ApbAddrWidth    = 3;
  localparam logic        RegHalfPeriod   = 1'b0;
  localparam logic [15:0] HalfPeriodRst   = 16'd500;

  typedef struct packed {
    logic       cmd_valid;
    logic [2:0] mode;
    logic [7:0] write_data;
    logic       sda_in;
  } in_t;

  typedef struct packed {
    logic       scl;
    logic       sda_release;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_byte;
    logic       ack_bit;
  } out_t;

  typedef struct packed {
    op_e        op;
    logic [2:0] bit_idx;
    logic [1:0] phase;
    logic [7:0] tx;
    logic [7:0] rx;
    logic       ack;
    logic       scl;
    logic       sda;
  } state_t;

endpackage

[rtl/i2cm_cfg.sv]
// apb register file holding the phase length
module i2cm_cfg (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [i2cm_pkg::ApbAddrWidth-1:0]  paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready,
  output logic [15:0]                        half_period_o
);
  import i2cm_pkg::*;

  logic [15:0] half_period_q;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready
                & (paddr[ApbAddrWidth-1] == RegHalfPeriod);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_period_q <= HalfPeriodRst;
    end else if (wr_en) begin
      half_period_q <= pwdata[15:0];
    end
  end

  always_comb begin
    prdata = 32'd0;
    if (paddr[ApbAddrWidth-1] == RegHalfPeriod) begin
      prdata = {16'd0, half_period_q};
    end
  end

  assign half_period_o = half_period_q;

endmodule

[rtl/i2cm_step.sv]
// next-state and result logic for one bus timer tick
module i2cm_step #(
  parameter int unsigned TIMER_WIDTH = 16
) (
  input  i2cm_pkg::state_t         state_i,
  input  logic [TIMER_WIDTH-1:0]   tick_i,
  input  logic [15:0]              half_period_i,
  input  i2cm_pkg::in_t            in_i,
  output i2cm_pkg::state_t         state_o,
  output logic [TIMER_WIDTH-1:0]   tick_o,
  output i2cm_pkg::out_t           res_o
);
  import i2cm_pkg::*;

  // {scl, sda} for phase s of a command
  function automatic logic [1:0] drive_lvl(op_e op, logic [1:0] s, logic b);
    logic [1:0] lv;
    case (op)
      OP_START: lv = {s < 2'd2, s == 2'd0};
      OP_STOP:  lv = {s > 2'd0, s == 2'd2};
      OP_WRITE: lv = {s == 2'd0, b};
      OP_ACK:   lv = {s == 2'd0, 1'b0};
      default:  lv = {s == 2'd0, 1'b1};
    endcase
    return lv;
  endfunction

  logic [TIMER_WIDTH-1:0] len_raw;
  logic [TIMER_WIDTH-1:0] len;
  state_t                 st;
  logic [TIMER_WIDTH-1:0] tk;
  logic [1:0]             ph_n;
  logic [1:0]             ph_cnt;
  logic                   scl_now;
  logic                   sda_now;
  logic                   done;

  // zero length acts as one tick
  assign len_raw = TIMER_WIDTH'(half_period_i);
  assign len     = (len_raw == '0) ? TIMER_WIDTH'(1) : len_raw;

  always_comb begin
    st     = state_i;
    tk     = tick_i;
    done   = 1'b0;
    ph_n   = 2'd0;
    ph_cnt = PhasesBit;

    // command launch, tick is the first of the first phase
    if (state_i.op == OP_IDLE && in_i.cmd_valid && in_i.mode != OP_IDLE) begin
      st.op      = op_e'(in_i.mode);
      st.phase   = 2'd0;
      st.bit_idx = 3'd0;
      tk         = '0;
      if (st.op == OP_WRITE) begin
        st.tx = in_i.write_data;
      end
      {st.scl, st.sda} = drive_lvl(st.op, st.phase, st.tx[7]);
    end

    scl_now = st.scl;
    sda_now = st.sda;

    if (st.op != OP_IDLE) begin
      tk = tk + TIMER_WIDTH'(1);
      if (tk >= len) begin
        tk = '0;
        // sample at the end of the scl-high phase
        if (st.phase == 2'd0) begin
          if (st.op == OP_READ) begin
            st.rx = {st.rx[6:0], in_i.sda_in};
          end else if (st.op == OP_WAIT_ACK) begin
            st.ack = in_i.sda_in;
          end
        end
        if (st.op == OP_WRITE && st.phase == 2'd1) begin
          st.tx = {st.tx[6:0], 1'b0};
        end
        ph_n   = st.phase + 2'd1;
        ph_cnt = (st.op == OP_START || st.op == OP_STOP) ? PhasesStartStop : PhasesBit;
        if (ph_n >= ph_cnt) begin
          if ((st.op == OP_WRITE || st.op == OP_READ) && st.bit_idx < LastBit) begin
            st.bit_idx = st.bit_idx + 3'd1;
            st.phase   = 2'd0;
            {st.scl, st.sda} = drive_lvl(st.op, st.phase, st.tx[7]);
          end else begin
            case (st.op)
              OP_START: {st.scl, st.sda} = 2'b00;
              OP_STOP:  {st.scl, st.sda} = 2'b11;
              default:  {st.scl, st.sda} = 2'b01;
            endcase
            st.op      = OP_IDLE;
            st.phase   = 2'd0;
            st.bit_idx = 3'd0;
            tk         = '0;
            done       = 1'b1;
          end
        end else begin
          st.phase = ph_n;
          {st.scl, st.sda} = drive_lvl(st.op, st.phase, st.tx[7]);
        end
      end
    end
  end

  assign state_o = st;
  assign tick_o  = tk;

  always_comb begin
    res_o.scl         = scl_now;
    res_o.sda_release = sda_now;
    res_o.busy_res    = (st.op != OP_IDLE);
    res_o.done_res    = done;
    res_o.read_byte   = st.rx;
    res_o.ack_bit     = st.ack;
  end

endmodule

[rtl/i2c_master_bit_engine.sv]
// i2c master bit engine: top level with tick handshake and apb config
// latency: an accepted tick beat shows its result beat in the next cycle, from the result register
// throughput: one tick per cycle while the input does not stall, set by the state update loop
// the input stalls only while the result register is full and the sink stalls
// reset: asynchronous active low, engine idle, scl and sda released,
// phase length 500 ticks, result register empty
module i2c_master_bit_engine #(
  parameter int unsigned TIMER_WIDTH = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // tick channel
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  i2cm_pkg::in_t                      in_data_i,
  // result channel
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output i2cm_pkg::out_t                     out_data_o,
  // configuration port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [i2cm_pkg::ApbAddrWidth-1:0]  paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);
  import i2cm_pkg::*;

  logic [15:0]            half_period;
  state_t                 state_q;
  state_t                 state_d;
  logic [TIMER_WIDTH-1:0] tick_q;
  logic [TIMER_WIDTH-1:0] tick_d;
  out_t                   res_d;
  out_t                   res_q;
  logic                   res_valid_q;
  logic                   accept;

  // phase length register behind the apb port
  i2cm_cfg u_cfg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .half_period_o (half_period)
  );

  // one tick of the sequencer, purely combinational
  i2cm_step #(
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_step (
    .state_i       (state_q),
    .tick_i        (tick_q),
    .half_period_i (half_period),
    .in_i          (in_data_i),
    .state_o       (state_d),
    .tick_o        (tick_d),
    .res_o         (res_d)
  );

  // a new beat is taken whenever the result register is empty or draining
  assign in_stall_o = res_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;

  // sequencer state, advanced once per accepted tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.op      <= OP_IDLE;
      state_q.bit_idx <= 3'd0;
      state_q.phase   <= 2'd0;
      state_q.tx      <= 8'd0;
      state_q.rx      <= 8'd0;
      state_q.ack     <= 1'b0;
      state_q.scl     <= 1'b1;
      state_q.sda     <= 1'b1;
      tick_q          <= '0;
    end else if (accept) begin
      state_q <= state_d;
      tick_q  <= tick_d;
    end
  end

  // result register valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (accept) begin
      res_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      res_valid_q <= 1'b0;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = res_valid_q;
  assign out_data_o  = res_q;

endmodule

[rtl/i2cm_checker.sv]
// port-level checker for the i2c master bit engine and its bind
`include "assert_macros.svh"

module i2cm_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_stall_i,
  input logic           out_valid_i,
  input logic           out_stall_i,
  input i2cm_pkg::out_t out_data_i
);
  import i2cm_pkg::*;

  // a stalled result beat holds
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && out_stall_i, out_valid_i && $stable(out_data_i), "stalled result beat changed")

  // input stalls only behind a full, stalled result register
  `ASSERT_SAME(a_stall_cause, clk_i, rst_ni, in_stall_i, out_valid_i && out_stall_i, "input stalled without a stalled result")

  // a completing tick leaves the engine idle
  `ASSERT_SAME(a_done_idle, clk_i, rst_ni, out_valid_i && out_data_i.done_res, !out_data_i.busy_res, "done pulse while still busy")

  // an accepted tick always yields a result beat next cycle
  `ASSERT_NEXT(a_beat_out, clk_i, rst_ni, in_valid_i && !in_stall_i, out_valid_i, "accepted tick gave no result beat")

endmodule

bind i2c_master_bit_engine i2cm_checker u_i2cm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_i  (in_stall_o),
  .out_valid_i (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_i  (out_data_o)
);
